>>> design/mexp_pkg.sv
// shared constants of the modular exponentiation block
`default_nettype none

package mexp_pkg;

    // default operand width in bits
    localparam int unsigned DEF_WIDTH = 16;

endpackage

`default_nettype wire

>>> design/modular_exponentiation.sv
// top level: modular exponentiation by left-to-right square-and-multiply
//
// channel   dir  handshake                        payload
// s_axis    in   s_axis_tvalid / s_axis_tready    tdata: message, exponent, modulus
// m_axis    out  m_axis_tvalid / m_axis_tready    tdata: result; tuser: bad_modulus
//
// one transaction at a time; a nonzero modulus and exponent take one
// reduction of the message plus one squaring per exponent bit and one
// multiply per set bit, each a pass of the bit-serial multiplier
// zero modulus or zero exponent skip the multiplier
// reset clears control only; a finished result waits in the output register
// while the next transaction is taken in
`default_nettype none

module modular_exponentiation #(
    parameter int unsigned WIDTH = mexp_pkg::DEF_WIDTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // message, exponent, modulus, from bit 0 up, zero padded to bytes
    input  wire logic [((3*WIDTH+7)/8)*8-1:0]        s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // result, zero padded to bytes
    output logic      [((WIDTH+7)/8)*8-1:0]          m_axis_tdata,
    // bad_modulus
    output logic                                     m_axis_tuser
);

    localparam int unsigned OTW = ((WIDTH + 7) / 8) * 8;
    localparam int unsigned CW  = $clog2(WIDTH + 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_BASE = 3'd1;   // message reduced mod n
    localparam logic [2:0] ST_SQR  = 3'd2;   // squaring of the accumulator
    localparam logic [2:0] ST_MUL  = 3'd3;   // multiply by the reduced base
    localparam logic [2:0] ST_DONE = 3'd4;   // result waits for the output register

    logic [2:0]       state_reg, state_next;
    logic [WIDTH-1:0] exp_reg, exp_next;     // exponent, shifted left per bit
    logic [WIDTH-1:0] mod_reg, mod_next;
    logic [WIDTH-1:0] base_reg, base_next;
    logic [WIDTH-1:0] res_reg, res_next;
    logic             bad_reg, bad_next;
    logic [CW-1:0]    bits_reg, bits_next;   // exponent bits still to go

    logic             mm_start_reg, mm_start_next;
    logic [WIDTH-1:0] mm_a_reg, mm_a_next;
    logic [WIDTH-1:0] mm_b_reg, mm_b_next;
    logic             mm_done;
    logic [WIDTH-1:0] mm_product;

    logic [WIDTH-1:0] out_data_reg;
    logic             out_bad_reg;
    logic             out_valid_reg;

    logic [WIDTH-1:0] in_msg;
    logic [WIDTH-1:0] in_exp;
    logic [WIDTH-1:0] in_mod;
    logic             in_fire;
    logic             out_load;

    assign in_msg  = s_axis_tdata[WIDTH-1:0];
    assign in_exp  = s_axis_tdata[2*WIDTH-1:WIDTH];
    assign in_mod  = s_axis_tdata[3*WIDTH-1:2*WIDTH];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire = s_axis_tvalid && s_axis_tready;

    // output register takes the result once it is free or being drained
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

    mexp_mulmod #(
        .WIDTH (WIDTH)
    ) u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start_reg),
        .a       (mm_a_reg),
        .b       (mm_b_reg),
        .n       (mod_reg),
        .done    (mm_done),
        .product (mm_product)
    );

    always_comb
    begin
        state_next    = state_reg;
        exp_next      = exp_reg;
        mod_next      = mod_reg;
        base_next     = base_reg;
        res_next      = res_reg;
        bad_next      = bad_reg;
        bits_next     = bits_reg;
        mm_start_next = 1'b0;
        mm_a_next     = mm_a_reg;
        mm_b_next     = mm_b_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    exp_next  = in_exp;
                    mod_next  = in_mod;
                    bits_next = CW'(WIDTH);
                    bad_next  = 1'b0;
                    if (in_mod == '0)
                    begin
                        res_next   = '0;
                        bad_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                    else if (in_exp == '0)
                    begin
                        // one, left unreduced even for a modulus of one
                        res_next   = WIDTH'(1);
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        // 1 * message mod n reduces the message
                        mm_start_next = 1'b1;
                        mm_a_next     = WIDTH'(1);
                        mm_b_next     = in_msg;
                        // accumulator starts at 1 mod n
                        res_next      = (in_mod == WIDTH'(1)) ? '0 : WIDTH'(1);
                        state_next    = ST_BASE;
                    end
                end
            end
            ST_BASE:
            begin
                if (mm_done)
                begin
                    base_next     = mm_product;
                    mm_start_next = 1'b1;
                    mm_a_next     = res_reg;
                    mm_b_next     = res_reg;
                    state_next    = ST_SQR;
                end
            end
            ST_SQR:
            begin
                if (mm_done)
                begin
                    res_next = mm_product;
                    if (exp_reg[WIDTH-1])
                    begin
                        mm_start_next = 1'b1;
                        mm_a_next     = mm_product;
                        mm_b_next     = base_reg;
                        state_next    = ST_MUL;
                    end
                    else
                    begin
                        exp_next  = {exp_reg[WIDTH-2:0], 1'b0};
                        bits_next = bits_reg - 1'b1;
                        if (bits_reg == CW'(1))
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            mm_start_next = 1'b1;
                            mm_a_next     = mm_product;
                            mm_b_next     = mm_product;
                        end
                    end
                end
            end
            ST_MUL:
            begin
                if (mm_done)
                begin
                    res_next  = mm_product;
                    exp_next  = {exp_reg[WIDTH-2:0], 1'b0};
                    bits_next = bits_reg - 1'b1;
                    if (bits_reg == CW'(1))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        mm_start_next = 1'b1;
                        mm_a_next     = mm_product;
                        mm_b_next     = mm_product;
                        state_next    = ST_SQR;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mm_start_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            mm_start_reg <= mm_start_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        exp_reg  <= exp_next;
        mod_reg  <= mod_next;
        base_reg <= base_next;
        res_reg  <= res_next;
        bad_reg  <= bad_next;
        bits_reg <= bits_next;
        mm_a_reg <= mm_a_next;
        mm_b_reg <= mm_b_next;
        if (out_load)
        begin
            out_data_reg <= res_reg;
            out_bad_reg  <= bad_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OTW'(out_data_reg);
    assign m_axis_tuser  = out_bad_reg;

endmodule

`default_nettype wire

>>> design/mexp_mulmod.sv
// bit-serial modular multiplier, one multiplier bit per cycle, msb first
`default_nettype none

module mexp_mulmod #(
    parameter int unsigned WIDTH = mexp_pkg::DEF_WIDTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] a,        // must be below n, latched at start
    input  wire logic [WIDTH-1:0] b,        // latched at start
    input  wire logic [WIDTH-1:0] n,        // nonzero, held by the caller during the run
    output logic                  done,
    output logic      [WIDTH-1:0] product
);

    localparam int unsigned CW = $clog2(WIDTH + 1);
    localparam int unsigned SW = WIDTH + 3;

    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] b_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [SW-1:0] sum;
    logic [SW-1:0] diff1;
    logic [SW-1:0] diff2;

    // 2*acc + bit*a stays below 3n, so subtract n or 2n at most
    always_comb
    begin
        sum   = {2'b00, acc_reg, 1'b0} + (b_reg[WIDTH-1] ? {3'b000, a_reg} : '0);
        diff1 = sum - {3'b000, n};
        diff2 = sum - {2'b00, n, 1'b0};
        if (!diff2[SW-1])
        begin
            acc_next = diff2[WIDTH-1:0];
        end
        else if (!diff1[SW-1])
        begin
            acc_next = diff1[WIDTH-1:0];
        end
        else
        begin
            acc_next = sum[WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(WIDTH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[WIDTH-2:0], 1'b0};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// testbench for the modular exponentiation block: stream driver, monitor and power predictor
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned W      = mexp_pkg::DEF_WIDTH;
    localparam int unsigned IN_W   = ((3*W+7)/8)*8;
    localparam int unsigned OUT_W  = ((W+7)/8)*8;
    localparam int unsigned N_RAND = 1150;
    // the stall limit covers the worst-case work of one transaction plus a long hold-off
    localparam int unsigned STALL_LIMIT = 20000;
    localparam int unsigned DRAIN_CYCLES = 700;
    localparam int unsigned HOLD_CYCLES = 2500;

    typedef struct packed {
        logic [W-1:0] modulus;
        logic [W-1:0] exponent;
        logic [W-1:0] message;
    } power_req_t;

    typedef struct packed {
        logic         bad_modulus;
        logic [W-1:0] result;
    } power_ans_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             m_axis_tuser;

    power_req_t requests_pending[$];
    power_ans_t answers_due[$];

    int unsigned n_sent = 0;
    int unsigned n_got = 0;
    int unsigned hold_left = 0;
    int unsigned errors = 0;

    modular_exponentiation #(.WIDTH(W)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // message^exponent mod modulus by square-and-multiply on exact 32-bit products
    function automatic power_ans_t predict_power(power_req_t req);
        power_ans_t  ans;
        logic [31:0] n;
        logic [31:0] base;
        logic [31:0] acc;
        ans = '0;
        n = {16'd0, req.modulus};
        if (req.modulus == '0)
        begin
            ans.bad_modulus = 1'b1;
        end
        else if (req.exponent == '0)
        begin
            // zero exponent gives 1 even for modulus 1
            ans.result = W'(1);
        end
        else
        begin
            base = {16'd0, req.message} % n;
            acc = 32'd1 % n;
            for (int b = W - 1; b >= 0; b--)
            begin
                acc = (acc * acc) % n;
                if (req.exponent[b])
                    acc = (acc * base) % n;
            end
            ans.result = acc[W-1:0];
        end
        return ans;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %0h, want %0h (result %0d)", what, got, want, n_got);
        errors++;
    endtask

    task automatic queue_request(logic [W-1:0] msg, logic [W-1:0] expo, logic [W-1:0] modu);
        power_req_t req;
        req.message = msg;
        req.exponent = expo;
        req.modulus = modu;
        requests_pending.push_back(req);
    endtask

    // driver: offers the head of the pending queue, holds it until it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                answers_due.push_back(predict_power(requests_pending[0]));
                requests_pending.pop_front();
                n_sent++;
            end
            if (s_axis_tvalid && !s_axis_tready)
            begin
                // offer stays up and unchanged until taken
            end
            else if (requests_pending.size() != 0 &&
                     ((n_sent >= 500 && n_sent < 650) || $urandom_range(99) >= 20))
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= IN_W'(requests_pending[0]);
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: checks each result transaction against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        power_ans_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (answers_due.size() == 0)
                begin
                    report_mismatch("unexpected result", 32'(m_axis_tdata), 32'd0);
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (m_axis_tdata[W-1:0] !== want.result)
                        report_mismatch("result", 32'(m_axis_tdata), 32'(want.result));
                    if (m_axis_tuser !== want.bad_modulus)
                        report_mismatch("bad_modulus", 32'(m_axis_tuser),
                                        32'(want.bad_modulus));
                end
                n_got++;
                // long back-pressure so the block fills and stalls its input
                if (n_got == 300 || n_got == 800)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (n_got >= 500 && n_got < 650)
            begin
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= 20);
            end
        end
    end

    // watchdog: ends the run when no transaction happens for too long
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int unsigned pick;
        logic [W-1:0] msg;
        logic [W-1:0] expo;
        logic [W-1:0] modu;

        // directed: field extremes and the special cases
        queue_request('0, '0, '0);
        queue_request('1, '1, '1);
        queue_request('1, '1, '0);               // zero modulus flags error
        queue_request(16'h1234, '0, '0);         // zero modulus wins over zero exponent
        queue_request(16'd5, '0, 16'd1);         // zero exponent gives 1 even mod 1
        queue_request('1, '0, '1);
        queue_request(16'd7, 16'd3, 16'd1);      // modulus 1 gives 0
        queue_request('1, 16'd3, 16'd7);         // message above modulus
        queue_request(16'd7, 16'd2, 16'd7);      // message equal to modulus
        queue_request('0, 16'd5, 16'd13);
        queue_request(16'd1, '1, 16'd65521);
        queue_request(16'd12345, 16'd1, 16'd65521);
        queue_request(16'd65534, 16'd2, '1);
        queue_request(16'd2, '1, 16'd2);
        queue_request(16'd3, 16'h8000, 16'd65521);
        queue_request(16'd42, 16'd17, 16'd3233); // small rsa key pair
        queue_request(16'd2557, 16'd2753, 16'd3233);
        queue_request('1, '1, 16'h8000);
        queue_request(16'hAAAA, 16'h5555, 16'hFFFE);
        queue_request(16'h5555, 16'hAAAA, 16'h7FFF);

        // random: mostly full-range operands, some special cases and small moduli
        for (int i = 0; i < N_RAND; i++)
        begin
            pick = $urandom_range(99);
            msg = W'($urandom);
            expo = W'($urandom);
            modu = W'($urandom);
            if (pick < 5)
                modu = '0;
            else if (pick < 10)
                expo = '0;
            else if (pick < 25)
                modu = W'($urandom_range(16, 1));
            else if (pick < 30)
                expo = W'($urandom_range(3, 1));
            if (pick >= 10 && pick < 40 && msg < modu && modu != '0)
                msg = msg + modu;
            queue_request(msg, expo, modu);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (requests_pending.size() != 0 || answers_due.size() != 0)
            @(posedge clk);
        // catch any stray result after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
